// ===== rtl/core/sggc_pkg.sv =====
// ---------------------------------------------------------------------------
// sggc_pkg
// Types and constants shared by the greedy graph coloring core.
// ---------------------------------------------------------------------------
package sggc_pkg;

    localparam int MAX_DEG      = 16;
    localparam int LOCAL_VERTS  = 1024;
    localparam int GLOBAL_VERTS = 4096;
    localparam int NPROC        = 16;
    localparam int NCOLORS      = MAX_DEG + 2;

    localparam int LV_W    = 10;
    localparam int SLOT_W  = 4;
    localparam int VID_W   = 13;
    localparam int GID_W   = 12;
    localparam int COL_W   = 5;
    localparam int LEN_W   = 11;
    localparam int DEG_W   = 5;
    localparam int VPP_W   = 13;
    localparam int STAMP_W = 11;
    localparam int ADJ_AW  = LV_W + SLOT_W;
    localparam int THR_W   = 17;
    localparam int CNT_W   = 13;

    typedef enum logic [2:0] {
        OP_INIT  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_WRITE = 3'd2,
        OP_PASS  = 3'd3,
        OP_CHECK = 3'd4,
        OP_READ  = 3'd5
    } op_t;

    localparam logic [1:0] CFG_VSTART = 2'd0;
    localparam logic [1:0] CFG_LCOUNT = 2'd1;
    localparam logic [1:0] CFG_VPP    = 2'd2;
    localparam logic [1:0] CFG_DEG    = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_THR,
        ST_LIST,
        ST_VERT,
        ST_OWN,
        ST_ADJ,
        ST_NB,
        ST_COL,
        ST_PICK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [GID_W-1:0] vstart;
        logic [LEN_W-1:0] lcount;
        logic [VPP_W-1:0] vpp;
        logic [DEG_W-1:0] deg;
    } cfg_t;

    typedef struct packed {
        logic              adj_we;
        logic [ADJ_AW-1:0] adj_waddr;
        logic [VID_W-1:0]  adj_wdata;
        logic [ADJ_AW-1:0] adj_raddr;
        logic              col_we;
        logic [GID_W-1:0]  col_waddr;
        logic [COL_W-1:0]  col_wdata;
        logic [GID_W-1:0]  col_raddr;
        logic              lst_we;
        logic [LV_W-1:0]   lst_waddr;
        logic [LV_W-1:0]   lst_wdata;
        logic [LV_W-1:0]   lst_raddr;
    } mem_req_t;

    typedef struct packed {
        logic [VID_W-1:0] adj_q;
        logic [COL_W-1:0] col_q;
        logic [LV_W-1:0]  lst_q;
    } mem_rsp_t;

endpackage

// ===== rtl/core/sggc_mem.sv =====
// ---------------------------------------------------------------------------
// sggc_mem
// Adjacency, color and work list memories, one write and one registered
// read port each.
// ---------------------------------------------------------------------------
module sggc_mem (
    input  logic                aclk,
    input  sggc_pkg::mem_req_t  req,
    output sggc_pkg::mem_rsp_t  rsp
);
    import sggc_pkg::*;

    logic [VID_W-1:0] adj_mem [LOCAL_VERTS*MAX_DEG];
    logic [COL_W-1:0] col_mem [GLOBAL_VERTS];
    logic [LV_W-1:0]  lst_mem [LOCAL_VERTS];
    logic [VID_W-1:0] adj_q_reg;
    logic [COL_W-1:0] col_q_reg;
    logic [LV_W-1:0]  lst_q_reg;

    always_ff @(posedge aclk) begin
        if (req.adj_we) begin
            adj_mem[req.adj_waddr] <= req.adj_wdata;
        end
        adj_q_reg <= adj_mem[req.adj_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.col_we) begin
            col_mem[req.col_waddr] <= req.col_wdata;
        end
        col_q_reg <= col_mem[req.col_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.lst_we) begin
            lst_mem[req.lst_waddr] <= req.lst_wdata;
        end
        lst_q_reg <= lst_mem[req.lst_raddr];
    end

    assign rsp.adj_q = adj_q_reg;
    assign rsp.col_q = col_q_reg;
    assign rsp.lst_q = lst_q_reg;

endmodule

// ===== rtl/core/sggc_engine.sv =====
// ---------------------------------------------------------------------------
// sggc_engine
// Sequencer for init, load, write, color pass, check and read operations.
// ---------------------------------------------------------------------------
module sggc_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sggc_pkg::cfg_t             cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 in_op,
    input  logic [sggc_pkg::LV_W-1:0]  in_lv,
    input  logic [sggc_pkg::SLOT_W-1:0] in_slot,
    input  logic [sggc_pkg::VID_W-1:0] in_vid,
    input  logic [sggc_pkg::COL_W-1:0] in_cin,
    output sggc_pkg::mem_req_t         req,
    input  sggc_pkg::mem_rsp_t         rsp,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [sggc_pkg::COL_W-1:0] out_color,
    output logic [sggc_pkg::LEN_W-1:0] out_remaining,
    output logic                       out_done,
    output logic [15:0]                out_mask
);
    import sggc_pkg::*;
    localparam int NPROC_BITS = 16;

    state_t               state_reg, state_next;
    logic                 init_clr_reg, init_clr_next;
    logic                 is_check_reg, is_check_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [LEN_W-1:0]     kept_reg, kept_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [NPROC-1:0]     mask_reg, mask_next;
    logic [LV_W-1:0]      v_reg, v_next;
    logic [DEG_W-1:0]     s_reg, s_next;
    logic [COL_W-1:0]     mine_reg, mine_next;
    logic [VID_W-1:0]     gid_reg, gid_next;
    logic [GID_W-1:0]     nb_reg, nb_next;
    logic [VID_W-1:0]     vid_reg, vid_next;
    logic [SLOT_W-1:0]    k_reg, k_next;
    logic [THR_W-1:0]     acc_reg, acc_next;
    logic [THR_W-1:0]     thr_reg [NPROC];
    logic [STAMP_W-1:0]   stamp_reg [NCOLORS];
    logic [COL_W-1:0]     rcol_reg, rcol_next;
    logic                 rdone_reg, rdone_next;
    logic                 mval_reg;
    logic [COL_W-1:0]     mcol_reg;
    logic [LEN_W-1:0]     mlen_reg;
    logic                 mdone_reg;
    logic [NPROC-1:0]     mmask_reg;

    logic                 accept;
    logic                 out_free;
    logic [DEG_W-1:0]     deg_eff;
    logic [THR_W-1:0]     div_eff;
    logic [LEN_W-1:0]     n_init;
    logic [VID_W-1:0]     gid_now;
    logic [STAMP_W-1:0]   mark;
    logic                 nb_end;
    logic [DEG_W-1:0]     s_inc;
    logic                 more_slots;
    logic                 more_verts;
    logic                 pick_found;
    logic [COL_W-1:0]     pick_col;
    logic [NPROC-1:0]     owner_hot;
    logic [THR_W-1:0]     nb_wide;
    logic                 stamp_we;
    logic                 thr_we;
    logic                 stamp_clr;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_free   = !mval_reg || out_ready;
    assign deg_eff    = (cfg.deg > DEG_W'(MAX_DEG)) ? DEG_W'(MAX_DEG) : cfg.deg;
    assign div_eff    = (cfg.vpp == '0) ? THR_W'(1) : THR_W'(cfg.vpp);
    assign n_init     = (cfg.lcount > LEN_W'(LOCAL_VERTS)) ? LEN_W'(LOCAL_VERTS)
                                                          : cfg.lcount;
    assign gid_now    = VID_W'(cfg.vstart) + VID_W'(rsp.lst_q);
    assign mark       = STAMP_W'(v_reg) + STAMP_W'(1);
    assign nb_end     = rsp.adj_q >= VID_W'(GLOBAL_VERTS);
    assign s_inc      = s_reg + DEG_W'(1);
    assign more_slots = s_inc < deg_eff;
    assign more_verts = (cnt_reg + CNT_W'(1)) < CNT_W'(len_reg);
    assign nb_wide    = THR_W'(rsp.adj_q[GID_W-1:0]);

    always_comb begin
        pick_found = 1'b0;
        pick_col   = '0;
        for (int c = NCOLORS - 1; c >= 1; c--) begin
            if ((COL_W'(c) <= COL_W'(deg_eff) + COL_W'(1)) && (stamp_reg[c] != mark)) begin
                pick_found = 1'b1;
                pick_col   = COL_W'(c);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NPROC; j++) begin
            owner_hot[j] = ((j == 0) || (nb_wide >= thr_reg[(j == 0) ? 0 : j - 1]))
                           && (nb_wide < thr_reg[j]);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (cnt_reg == CNT_W'(GLOBAL_VERTS - 1)) begin
                    state_next = init_clr_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_INIT:  state_next = ST_CLEAR;
                        OP_PASS:  state_next = ST_THR;
                        OP_CHECK: state_next = (len_reg == '0) ? ST_FIN : ST_LIST;
                        OP_READ:  state_next = ST_RD_WAIT;
                        default:  state_next = ST_FIN;
                    endcase
                end
            end
            ST_RD_WAIT: state_next = ST_FIN;
            ST_THR: begin
                if (k_reg == SLOT_W'(NPROC - 1)) begin
                    state_next = (len_reg == '0) ? ST_FIN : ST_LIST;
                end
            end
            ST_LIST: state_next = ST_VERT;
            ST_VERT: begin
                if (is_check_reg) begin
                    state_next = ST_OWN;
                end else begin
                    state_next = (deg_eff == '0) ? ST_PICK : ST_ADJ;
                end
            end
            ST_OWN: begin
                if (deg_eff != '0) begin
                    state_next = ST_ADJ;
                end else begin
                    state_next = more_verts ? ST_LIST : ST_FIN;
                end
            end
            ST_ADJ: state_next = ST_NB;
            ST_NB: begin
                if (!nb_end) begin
                    state_next = ST_COL;
                end else if (!is_check_reg) begin
                    state_next = ST_PICK;
                end else begin
                    state_next = more_verts ? ST_LIST : ST_FIN;
                end
            end
            ST_COL: begin
                if (!is_check_reg) begin
                    state_next = more_slots ? ST_ADJ : ST_PICK;
                end else if ((rsp.col_q != mine_reg) && more_slots) begin
                    state_next = ST_ADJ;
                end else begin
                    state_next = more_verts ? ST_LIST : ST_FIN;
                end
            end
            ST_PICK: state_next = more_verts ? ST_LIST : ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb begin
        req           = '0;
        req.adj_raddr = {v_reg, s_reg[SLOT_W-1:0]};
        req.lst_raddr = cnt_reg[LV_W-1:0];
        req.col_raddr = gid_reg[GID_W-1:0];
        init_clr_next = init_clr_reg;
        is_check_next = is_check_reg;
        cnt_next      = cnt_reg;
        kept_next     = kept_reg;
        len_next      = len_reg;
        mask_next     = mask_reg;
        v_next        = v_reg;
        s_next        = s_reg;
        mine_next     = mine_reg;
        gid_next      = gid_reg;
        nb_next       = nb_reg;
        vid_next      = vid_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        rcol_next     = rcol_reg;
        rdone_next    = rdone_reg;
        stamp_we      = 1'b0;
        thr_we        = 1'b0;
        stamp_clr     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                req.col_we    = 1'b1;
                req.col_waddr = cnt_reg[GID_W-1:0];
                req.col_wdata = '0;
                req.lst_we    = cnt_reg < CNT_W'(len_reg);
                req.lst_waddr = cnt_reg[LV_W-1:0];
                req.lst_wdata = cnt_reg[LV_W-1:0];
                cnt_next      = cnt_reg + CNT_W'(1);
            end
            ST_IDLE: begin
                req.col_raddr = in_vid[GID_W-1:0];
                if (accept) begin
                    rcol_next     = '0;
                    rdone_next    = 1'b0;
                    cnt_next      = '0;
                    kept_next     = '0;
                    k_next        = '0;
                    acc_next      = '0;
                    vid_next      = in_vid;
                    is_check_next = (in_op == OP_CHECK);
                    case (in_op)
                        OP_INIT: begin
                            init_clr_next = 1'b1;
                            len_next      = n_init;
                            mask_next     = '0;
                            stamp_clr     = 1'b1;
                        end
                        OP_LOAD: begin
                            req.adj_we    = 1'b1;
                            req.adj_waddr = {in_lv, in_slot};
                            req.adj_wdata = in_vid;
                        end
                        OP_WRITE: begin
                            req.col_we    = in_vid < VID_W'(GLOBAL_VERTS);
                            req.col_waddr = in_vid[GID_W-1:0];
                            req.col_wdata = in_cin;
                        end
                        OP_CHECK: begin
                            if (len_reg == '0) begin
                                rdone_next = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                rcol_next = (vid_reg < VID_W'(GLOBAL_VERTS)) ? rsp.col_q : '0;
            end
            ST_THR: begin
                thr_we   = 1'b1;
                acc_next = acc_reg + div_eff;
                k_next   = k_reg + SLOT_W'(1);
            end
            ST_VERT: begin
                v_next        = rsp.lst_q;
                gid_next      = gid_now;
                s_next        = '0;
                req.col_raddr = gid_now[GID_W-1:0];
            end
            ST_OWN: begin
                mine_next = gid_reg[GID_W] ? '0 : rsp.col_q;
                if (deg_eff == '0) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_NB: begin
                nb_next       = rsp.adj_q[GID_W-1:0];
                req.col_raddr = rsp.adj_q[GID_W-1:0];
                if (!nb_end && !is_check_reg) begin
                    mask_next = mask_reg | owner_hot;
                end
                if (nb_end && is_check_reg) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_COL: begin
                s_next = s_inc;
                if (!is_check_reg) begin
                    stamp_we = 1'b1;
                end else if (rsp.col_q == mine_reg) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (gid_reg > VID_W'(nb_reg)) begin
                        req.lst_we    = 1'b1;
                        req.lst_waddr = kept_reg[LV_W-1:0];
                        req.lst_wdata = v_reg;
                        kept_next     = kept_reg + LEN_W'(1);
                    end
                end else if (!more_slots) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_PICK: begin
                req.col_we    = pick_found && !gid_reg[GID_W];
                req.col_waddr = gid_reg[GID_W-1:0];
                req.col_wdata = pick_col;
                cnt_next      = cnt_reg + CNT_W'(1);
            end
            default: begin
            end
        endcase
        if ((state_next == ST_FIN) && (state_reg != ST_FIN) && is_check_reg
            && (state_reg != ST_IDLE)) begin
            len_next   = kept_next;
            rdone_next = (kept_next == '0);
        end
        if ((state_reg == ST_CLEAR) && (state_next != ST_CLEAR)) begin
            init_clr_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            init_clr_reg <= 1'b0;
            cnt_reg      <= '0;
            len_reg      <= '0;
            mask_reg     <= '0;
            mval_reg     <= 1'b0;
            for (int c = 0; c < NCOLORS; c++) begin
                stamp_reg[c] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            init_clr_reg <= init_clr_next;
            cnt_reg      <= cnt_next;
            len_reg      <= len_next;
            mask_reg     <= mask_next;
            for (int c = 0; c < NCOLORS; c++) begin
                if (stamp_clr) begin
                    stamp_reg[c] <= '0;
                end else if (stamp_we && (rsp.col_q == COL_W'(c))) begin
                    stamp_reg[c] <= mark;
                end
            end
            if ((state_reg == ST_FIN) && out_free) begin
                mval_reg <= 1'b1;
            end else if (out_ready) begin
                mval_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        is_check_reg <= is_check_next;
        kept_reg     <= kept_next;
        v_reg        <= v_next;
        s_reg        <= s_next;
        mine_reg     <= mine_next;
        gid_reg      <= gid_next;
        nb_reg       <= nb_next;
        vid_reg      <= vid_next;
        k_reg        <= k_next;
        acc_reg      <= acc_next;
        rcol_reg     <= rcol_next;
        rdone_reg    <= rdone_next;
        if (thr_we) begin
            thr_reg[k_reg] <= acc_next;
        end
        if ((state_reg == ST_FIN) && out_free) begin
            mcol_reg  <= rcol_reg;
            mlen_reg  <= len_reg;
            mdone_reg <= rdone_reg;
            mmask_reg <= mask_reg;
        end
    end

    assign out_valid     = mval_reg;
    assign out_color     = mcol_reg;
    assign out_remaining = mlen_reg;
    assign out_done      = mdone_reg;
    assign out_mask      = NPROC_BITS'(mmask_reg);

`ifndef SYNTH
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start an operation");
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(LOCAL_VERTS))
        else $error("work list length out of range");
    a_kept_behind_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LIST) |-> (CNT_W'(kept_reg) <= cnt_reg))
        else $error("list rebuild overtook list read");
    a_fin_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FIN) && out_free) |=> out_valid)
        else $error("finished operation produced no result");
`endif

endmodule

// ===== rtl/core/speculative_greedy_graph_coloring_core.sv =====
// ---------------------------------------------------------------------------
// speculative_greedy_graph_coloring_core
// Speculative greedy graph coloring with conflict check, memory based.
//
// Channel  Dir  Transfer              Payload
// s_       in   s_tvalid & s_tready   tdata: item fields, tuser: operation
// m_       out  m_tvalid & m_tready   tdata: result fields
// cfg_     in   cfg_valid & cfg_ready cfg_index, cfg_data
//
// Init and the reset clear sweep the whole color memory. A color pass
// first builds the 16-entry owner table; check is alike without it.
// A waiting result does not block the next operation until it finishes.
// ---------------------------------------------------------------------------
module speculative_greedy_graph_coloring_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // local_vertex[9:0], slot[13:10], vertex_id[26:14],
                                   // color_in[31:27]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // color_out[4:0], remaining[15:5], done_res[16],
                                   // touched_mask[32:17], zero[39:33]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import sggc_pkg::*;

    cfg_t               cfg_reg;
    mem_req_t           req;
    mem_rsp_t           rsp;
    logic [COL_W-1:0]   out_color;
    logic [LEN_W-1:0]   out_remaining;
    logic               out_done;
    logic [15:0]        out_mask;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vstart <= '0;
            cfg_reg.lcount <= LEN_W'(1024);
            cfg_reg.vpp    <= VPP_W'(256);
            cfg_reg.deg    <= DEG_W'(16);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_VSTART: cfg_reg.vstart <= cfg_data[GID_W-1:0];
                CFG_LCOUNT: cfg_reg.lcount <= cfg_data[LEN_W-1:0];
                CFG_VPP:    cfg_reg.vpp    <= cfg_data[VPP_W-1:0];
                CFG_DEG:    cfg_reg.deg    <= cfg_data[DEG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sggc_mem u_mem (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    sggc_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_op         (s_tuser),
        .in_lv         (s_tdata[9:0]),
        .in_slot       (s_tdata[13:10]),
        .in_vid        (s_tdata[26:14]),
        .in_cin        (s_tdata[31:27]),
        .req           (req),
        .rsp           (rsp),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_color     (out_color),
        .out_remaining (out_remaining),
        .out_done      (out_done),
        .out_mask      (out_mask)
    );

    assign m_tdata = {7'd0, out_mask, out_done, out_remaining, out_color};

endmodule

// ===== tb/speculative_greedy_graph_coloring_core_test.sv =====
// ---------------------------------------------------------------------------
// speculative_greedy_graph_coloring_core_test
// Self-checking bench for the graph coloring core: a cycle-free predictor
// tracks adjacency, colors, stamps, work list and process mask, and every
// result transfer is compared field by field against the oldest prediction.
// Small graphs are loaded, then colored and checked in rounds under random
// idling on both channels.
// ---------------------------------------------------------------------------
module speculative_greedy_graph_coloring_core_test;
    import sggc_pkg::*;

    typedef struct packed {
        logic [15:0]      mask;
        logic             done;
        logic [LEN_W-1:0] remaining;
        logic [COL_W-1:0] color;
    } coloring_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;

    logic [VID_W-1:0] adj_mem [LOCAL_VERTS*MAX_DEG];
    bit               adj_written [LOCAL_VERTS*MAX_DEG];
    logic [COL_W-1:0] color_mem [GLOBAL_VERTS];
    logic [STAMP_W-1:0] stamp_mem [NCOLORS];
    logic [LV_W-1:0]  list_mem [LOCAL_VERTS];
    int               list_len;
    logic [15:0]      proc_mask;
    int               cur_vstart, cur_lcount, cur_vpp, cur_deg;

    coloring_result_t pending_results[$];
    int  errors, items_sent, results_seen, passes_run, checks_run, phases_run;
    bit  quiet;
    int  hold_cycles;
    int  ready_burst;

    always #4 aclk = ~aclk;

    speculative_greedy_graph_coloring_core DUT (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
    endtask

    function automatic coloring_result_t predict_coloring(input op_t op, input int lv,
            input int slot, input int vid, input int cin);
        coloring_result_t r;
        int deg, dv, v, mark, nb, owner, c, gid, kept, mine;
        r = '0;
        deg = cur_deg > MAX_DEG ? MAX_DEG : cur_deg;
        dv = cur_vpp == 0 ? 1 : cur_vpp;
        case (op)
            OP_INIT: begin
                list_len = cur_lcount > LOCAL_VERTS ? LOCAL_VERTS : cur_lcount;
                for (int i = 0; i < list_len; i++) list_mem[i] = i;
                foreach (color_mem[i]) color_mem[i] = '0;
                foreach (stamp_mem[i]) stamp_mem[i] = '0;
                proc_mask = '0;
            end
            OP_LOAD: begin
                adj_mem[lv*MAX_DEG+slot] = vid;
                adj_written[lv*MAX_DEG+slot] = 1'b1;
            end
            OP_WRITE: if (vid < GLOBAL_VERTS) color_mem[vid] = cin;
            OP_PASS: begin
                for (int i = 0; i < list_len; i++) begin
                    v = list_mem[i];
                    mark = v + 1;
                    for (int s = 0; s < deg; s++) begin
                        nb = adj_mem[v*MAX_DEG+s];
                        if (nb >= GLOBAL_VERTS) break;
                        owner = nb / dv;
                        if (owner < NPROC && owner < 16) proc_mask[owner] = 1'b1;
                        c = color_mem[nb];
                        if (c < NCOLORS) stamp_mem[c] = mark;
                    end
                    gid = cur_vstart + v;
                    for (c = 1; c <= deg + 1; c++) begin
                        if (stamp_mem[c] != mark) begin
                            if (gid < GLOBAL_VERTS) color_mem[gid] = c;
                            break;
                        end
                    end
                end
            end
            OP_CHECK: begin
                kept = 0;
                for (int i = 0; i < list_len; i++) begin
                    v = list_mem[i];
                    gid = cur_vstart + v;
                    mine = gid < GLOBAL_VERTS ? color_mem[gid] : 0;
                    for (int s = 0; s < deg; s++) begin
                        nb = adj_mem[v*MAX_DEG+s];
                        if (nb >= GLOBAL_VERTS) break;
                        if (color_mem[nb] == mine) begin
                            if (gid > nb) list_mem[kept++] = v;
                            break;
                        end
                    end
                end
                list_len = kept;
                r.done = list_len == 0;
            end
            OP_READ: r.color = vid < GLOBAL_VERTS ? color_mem[vid] : '0;
            default: ;
        endcase
        r.remaining = list_len;
        r.mask = proc_mask;
        return r;
    endfunction

    task automatic send_item(input op_t op, input int lv, input int slot, input int vid,
            input int cin);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {cin[4:0], vid[12:0], slot[3:0], lv[9:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_coloring(op, lv, slot, vid, cin));
        items_sent++;
        if (op == OP_PASS) passes_run++;
        if (op == OP_CHECK) checks_run++;
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input int value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[12:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_VSTART: cur_vstart = value & 12'hFFF;
            CFG_LCOUNT: cur_lcount = value & 11'h7FF;
            CFG_VPP:    cur_vpp    = value & 13'h1FFF;
            default:    cur_deg    = value & 5'h1F;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int vs, input int lc, input int vpp, input int deg);
        write_register(CFG_VSTART, vs);
        write_register(CFG_LCOUNT, lc);
        write_register(CFG_VPP, vpp);
        write_register(CFG_DEG, deg);
    endtask

    // terminate any scan that would reach a never-loaded slot
    task automatic seal_scans();
        int v, deg;
        deg = cur_deg > MAX_DEG ? MAX_DEG : cur_deg;
        for (int i = 0; i < list_len; i++) begin
            v = list_mem[i];
            for (int s = 0; s < deg; s++) begin
                if (!adj_written[v*MAX_DEG+s]) begin
                    send_item(OP_LOAD, v, s, GLOBAL_VERTS, 0);
                    break;
                end
                if (adj_mem[v*MAX_DEG+s] >= GLOBAL_VERTS) break;
            end
        end
    endtask

    task automatic run_scan(input op_t op);
        seal_scans();
        send_item(op, $urandom_range(0, 1023), $urandom_range(0, 15), $urandom_range(0, 4096),
                  $urandom_range(0, 17));
    endtask

    function automatic int pick_neighbor();
        int nb;
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 4095);
        nb = cur_vstart + $urandom_range(0, cur_lcount == 0 ? 0 : cur_lcount - 1);
        return nb < GLOBAL_VERTS ? nb : $urandom_range(0, 4095);
    endfunction

    task automatic random_noise();
        case ($urandom_range(0, 2))
            0: send_item(OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 15),
                         $urandom_range(0, 4096), $urandom_range(0, 17));
            1: send_item(OP_READ, $urandom_range(0, 1023), $urandom_range(0, 15),
                         $urandom_range(0, 4096), $urandom_range(0, 17));
            default: send_item(OP_LOAD, $urandom_range(0, 1023), $urandom_range(0, 15),
                               $urandom_range(0, 4096), $urandom_range(0, 17));
        endcase
    endtask

    task automatic test_directed();
        configure(0, 8, 1, 16);
        send_item(OP_INIT, 0, 0, 0, 0);
        send_item(OP_LOAD, 0, 0, 1, 0);
        send_item(OP_LOAD, 0, 1, 4095, 31);
        send_item(OP_LOAD, 0, 2, 4096, 0);
        send_item(OP_LOAD, 1, 0, 0, 0);
        send_item(OP_LOAD, 1, 1, 2, 0);
        send_item(OP_LOAD, 2, 0, 1, 0);
        send_item(OP_LOAD, 2, 15, 100, 0);
        send_item(OP_LOAD, 1023, 15, 4096, 0);
        send_item(OP_WRITE, 0, 0, 4095, 17);
        send_item(OP_WRITE, 0, 0, 4096, 17);
        send_item(OP_WRITE, 0, 0, 100, 16);
        send_item(OP_READ, 0, 0, 4096, 0);
        send_item(OP_READ, 0, 0, 4095, 0);
        run_scan(OP_PASS);
        run_scan(OP_CHECK);
        run_scan(OP_PASS);
        run_scan(OP_CHECK);
        send_item(OP_READ, 0, 0, 1, 0);
        send_item(OP_READ, 0, 0, 2, 0);
        send_item(OP_READ, 1023, 15, 0, 17);
    endtask

    task automatic run_phase(input int vs, input int lc, input int vpp, input int deg);
        configure(vs, lc, vpp, deg);
        phases_run++;
        send_item(OP_INIT, 0, 0, 0, 0);
        for (int v = 0; v < lc; v++) begin
            int n;
            n = $urandom_range(0, deg);
            for (int s = 0; s < n; s++) send_item(OP_LOAD, v, s, pick_neighbor(), 0);
            if (n < MAX_DEG && $urandom_range(0, 1)) send_item(OP_LOAD, v, n, GLOBAL_VERTS, 0);
            if ($urandom_range(0, 7) == 0) random_noise();
        end
        for (int round = 0; round < 6; round++) begin
            run_scan(OP_PASS);
            repeat ($urandom_range(0, 3)) random_noise();
            run_scan(OP_CHECK);
            if (list_len == 0) break;
        end
        repeat (4) send_item(OP_READ, 0, 0, cur_vstart + $urandom_range(0, 15), 0);
    endtask

    task automatic test_random_phases();
        run_phase(0, 20, 1, 16);
        run_phase(4095, 12, 4096, 1);
        run_phase(0, 0, 256, 8);
        while (items_sent < 1740) begin
            run_phase($urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 64),
                      $urandom_range(1, 24), $urandom_range(0, 1) ? $urandom_range(1, 4096)
                      : $urandom_range(1, 8), $urandom_range(1, 16));
        end
    endtask

    task automatic test_full_list();
        configure(0, 1024, 256, 16);
        send_item(OP_INIT, 0, 0, 0, 0);
        repeat (10) random_noise();
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        repeat (60) random_noise();
    endtask

    task automatic test_quiet_tail();
        quiet = 1'b1;
        run_phase(16, 16, 2, 4);
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else if (ready_burst > 0) begin
            ready_burst <= ready_burst - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            ready_burst <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        coloring_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[32:0];
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.color != want.color) report_mismatch("color_out", got.color, want.color);
                if (got.remaining != want.remaining)
                    report_mismatch("remaining", got.remaining, want.remaining);
                if (got.done != want.done) report_mismatch("done_res", got.done, want.done);
                if (got.mask != want.mask) report_mismatch("touched_mask", got.mask, want.mask);
                if (m_tdata[39:33] != '0) report_mismatch("pad bits", m_tdata[39:33], 0);
            end
        end
    end

    initial begin
        #(8 * 4000000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        foreach (color_mem[i]) color_mem[i] = '0;
        foreach (stamp_mem[i]) stamp_mem[i] = '0;
        list_len = 0;
        proc_mask = '0;
        cur_vstart = 0;
        cur_lcount = 1024;
        cur_vpp = 256;
        cur_deg = 16;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_backpressure();
        test_random_phases();
        test_full_list();
        test_quiet_tail();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (pending_results.size() != 0) report_mismatch("results left over", 1, 0);
        $display("Covered %0d items in %0d phases: %0d color passes, %0d checks, %0d results.",
                 items_sent, phases_run, passes_run, checks_run, results_seen);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/sggc_pkg.sv
rtl/core/sggc_mem.sv
rtl/core/sggc_engine.sv
rtl/core/speculative_greedy_graph_coloring_core.sv
tb/speculative_greedy_graph_coloring_core_test.sv
